// ===== rtl/core/pxe_pkg.sv =====
package pxe_pkg;

	typedef enum logic [1:0] {
		MODE_FULL   = 2'd0,
		MODE_CUTOFF = 2'd1,
		MODE_KEY    = 2'd2,
		MODE_NONE   = 2'd3
	} alpha_mode_t;

	typedef enum logic [2:0] {
		REG_ALPHA_MODE = 3'd0,
		REG_GRAY_OUT   = 3'd1,
		REG_THRESHOLD  = 3'd2,
		REG_KEY_COLOR  = 3'd3,
		REG_FILL_COLOR = 3'd4
	} reg_index_t;

	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	localparam logic [15:0] GRAY_WR   = 16'd19595;
	localparam logic [15:0] GRAY_WG   = 16'd38470;
	localparam logic [15:0] GRAY_WB   = 16'd7471;
	localparam logic [23:0] GRAY_HALF = 24'd32768;

	localparam logic [7:0] BYTE_MAX = 8'd255;

endpackage

// ===== rtl/core/pxe_div_lane.sv =====
// One color channel: (c*255 + a/2) / a by reciprocal multiply, one correction step,
// saturate at 255. Zero alpha gives 0. Four register stages.
module pxe_div_lane (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] chan,
	input  logic [7:0] alpha,
	output logic [7:0] quot
);

	logic [pxe_pkg::RECIP_W-1:0] recip_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_recip
		localparam longint unsigned RV =
			(64'd1 << pxe_pkg::RECIP_SHIFT) / ((i == 0) ? 1 : i);
		assign recip_tab[i] = pxe_pkg::RECIP_W'(RV);
	end

	logic [15:0]                   n_s1, n_s2, n_s3;
	logic [pxe_pkg::RECIP_W-1:0]   recip_s1;
	logic [7:0]                    a_s1, a_s2, a_s3;
	logic [pxe_pkg::RECIP_W+15:0]  prod_s2;
	logic [15:0]                   q0_s3;
	logic [23:0]                   qa_s3;
	logic [15:0]                   q0;
	logic [23:0]                   rem;
	logic [16:0]                   q1;
	logic [7:0]                    quot_s4;

	assign q0 = prod_s2[pxe_pkg::RECIP_SHIFT+15:pxe_pkg::RECIP_SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= {chan, 8'h00} - {8'h00, chan} + {9'h000, alpha[7:1]};
			recip_s1 <= recip_tab[alpha];
			a_s1     <= alpha;
			prod_s2  <= n_s1 * recip_s1;
			n_s2     <= n_s1;
			a_s2     <= a_s1;
			q0_s3    <= q0;
			qa_s3    <= q0 * a_s2;
			n_s3     <= n_s2;
			a_s3     <= a_s2;
			quot_s4  <= quot_next();
		end
	end

	// estimate is low by at most one; bump it when the remainder reaches alpha
	assign rem = {8'h00, n_s3} - qa_s3;
	assign q1  = {1'b0, q0_s3} + 17'((rem >= {16'h0000, a_s3}) ? 1 : 0);

	function automatic logic [7:0] quot_next();
		if (a_s3 == 8'd0)
			return 8'd0;
		else if (q1 > 17'(pxe_pkg::BYTE_MAX))
			return pxe_pkg::BYTE_MAX;
		else
			return q1[7:0];
	endfunction

	assign quot = quot_s4;

endmodule

// ===== rtl/core/pxe_gray.sv =====
// BT.601 luma in 16-bit fixed point: weighted products registered, then summed.
module pxe_gray (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] gray
);

	logic [23:0] pr_s1, pg_s1, pb_s1;
	logic [23:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1 <= pxe_pkg::GRAY_WR * red;
			pg_s1 <= pxe_pkg::GRAY_WG * green;
			pb_s1 <= pxe_pkg::GRAY_WB * blue;
		end
	end

	// weights sum to 65536, so the rounded sum never leaves 24 bits
	assign sum  = pr_s1 + pg_s1 + pb_s1 + pxe_pkg::GRAY_HALF;
	assign gray = sum[23:16];

endmodule

// ===== rtl/core/premultiplied_pixel_export.sv =====
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Stages 1-4 un-premultiply (reciprocal table, multiply, back-multiply, correct),
// stage 5 applies the alpha mode, stage 6 the gray products, stage 7 packs.
// Reset clears valid bits and restores register defaults; data registers keep junk.
module premultiplied_pixel_export (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  red_in,
	input  logic [7:0]  alpha_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte0,
	output logic [7:0]  byte1,
	output logic [7:0]  byte2,
	output logic [7:0]  byte3,
	output logic [2:0]  byte_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// configuration registers
	pxe_pkg::alpha_mode_t mode_q;
	logic        gray_q;
	logic [7:0]  thr_q;
	logic [23:0] key_q;
	logic [23:0] fill_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pxe_pkg::MODE_FULL;
			gray_q <= 1'b0;
			thr_q  <= 8'd64;
			key_q  <= 24'hFF00FF;
			fill_q <= 24'hFFFFFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				pxe_pkg::REG_ALPHA_MODE: mode_q <= pxe_pkg::alpha_mode_t'(cfg_data[1:0]);
				pxe_pkg::REG_GRAY_OUT:   gray_q <= cfg_data[0];
				pxe_pkg::REG_THRESHOLD:  thr_q  <= cfg_data[7:0];
				pxe_pkg::REG_KEY_COLOR:  key_q  <= cfg_data;
				pxe_pkg::REG_FILL_COLOR: fill_q <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// one enable for every stage: advance unless the output holds an untaken result
	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// un-premultiply lanes, four stages each
	logic [7:0] r_div, g_div, b_div;

	pxe_div_lane u_red   (.clk, .en(advance), .chan(red_in),   .alpha(alpha_in), .quot(r_div));
	pxe_div_lane u_green (.clk, .en(advance), .chan(green_in), .alpha(alpha_in), .quot(g_div));
	pxe_div_lane u_blue  (.clk, .en(advance), .chan(blue_in),  .alpha(alpha_in), .quot(b_div));

	// original alpha rides alongside the lanes
	logic [7:0] a_s1, a_s2, a_s3, a_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1 <= alpha_in;
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
		end
	end

	// alpha mode: decide output alpha and whether the fill color replaces the pixel
	logic [7:0] a_mode;
	logic       fill;
	logic       key_hit;

	assign key_hit = ({r_div, g_div, b_div} == key_q);

	always_comb begin
		a_mode = a_s4;
		fill   = 1'b0;
		case (mode_q)
			pxe_pkg::MODE_FULL: begin
				a_mode = a_s4;
				fill   = 1'b0;
			end
			pxe_pkg::MODE_CUTOFF: begin
				a_mode = (a_s4 >= thr_q) ? pxe_pkg::BYTE_MAX : 8'd0;
				fill   = (a_s4 < thr_q);
			end
			pxe_pkg::MODE_KEY: begin
				a_mode = key_hit ? 8'd0 : pxe_pkg::BYTE_MAX;
				fill   = key_hit;
			end
			pxe_pkg::MODE_NONE: begin
				a_mode = pxe_pkg::BYTE_MAX;
				fill   = (a_s4 == 8'd0);
			end
			default: begin
				a_mode = a_s4;
				fill   = 1'b0;
			end
		endcase
	end

	logic [7:0] r_s5, g_s5, b_s5, a_s5;
	logic [7:0] r_s6, g_s6, b_s6, a_s6;

	always_ff @(posedge clk) begin
		if (advance) begin
			r_s5 <= fill ? fill_q[23:16] : r_div;
			g_s5 <= fill ? fill_q[15:8]  : g_div;
			b_s5 <= fill ? fill_q[7:0]   : b_div;
			a_s5 <= a_mode;
			r_s6 <= r_s5;
			g_s6 <= g_s5;
			b_s6 <= b_s5;
			a_s6 <= a_s5;
		end
	end

	logic [7:0] gray;

	pxe_gray u_gray (
		.clk,
		.en(advance),
		.red(r_s5),
		.green(g_s5),
		.blue(b_s5),
		.gray
	);

	// pack into the output registers; unused bytes are zero
	logic with_alpha;
	assign with_alpha = (mode_q != pxe_pkg::MODE_NONE);

	always_ff @(posedge clk) begin
		if (advance) begin
			if (gray_q) begin
				byte0      <= gray;
				byte1      <= with_alpha ? a_s6 : 8'd0;
				byte2      <= 8'd0;
				byte3      <= 8'd0;
				byte_count <= with_alpha ? 3'd2 : 3'd1;
			end else begin
				byte0      <= r_s6;
				byte1      <= g_s6;
				byte2      <= b_s6;
				byte3      <= with_alpha ? a_s6 : 8'd0;
				byte_count <= with_alpha ? 3'd4 : 3'd3;
			end
		end
	end

	assign out_valid = v_s7;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

	// Pipeline depth of the block; used for the idle wait before register writes
	// and at the end of the run.
	localparam int PIPE_LAT = 7;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] cnt;
	} packed_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  blue_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  red_in = '0;
	logic [7:0]  alpha_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [2:0]  byte_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// Shadow copy of the block's registers.
	pxe_pkg::alpha_mode_t sh_mode;
	logic        sh_gray;
	logic [7:0]  sh_thresh;
	logic [23:0] sh_key;
	logic [23:0] sh_fill;

	packed_px_t  pending_px[$];
	int          err_cnt = 0;
	bit          sink_idle_ok = 1'b1;
	int          sink_hold = 0;
	logic        long_hold = 1'b0;

	premultiplied_pixel_export u_top (.*);

	always #2 clk = ~clk;

	// Divide one channel back to straight color, rounded, saturated at 255.
	function automatic logic [7:0] straighten(input logic [7:0] c, input logic [7:0] a);
		int unsigned v;
		v = (int'(c) * 255 + (int'(a) >> 1)) / int'(a);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic packed_px_t export_pixel(input logic [7:0] bi, input logic [7:0] gi,
			input logic [7:0] ri, input logic [7:0] ai);
		logic [7:0]  r, g, b, a;
		logic        fill, with_a;
		longint unsigned gy;
		packed_px_t  p;
		r = ri; g = gi; b = bi; a = ai;
		fill = 1'b0;
		with_a = (sh_mode != pxe_pkg::MODE_NONE);
		if (ai == 8'd0) begin
			r = '0; g = '0; b = '0;
		end else if (ai != 8'd255) begin
			r = straighten(ri, ai);
			g = straighten(gi, ai);
			b = straighten(bi, ai);
		end
		case (sh_mode)
			pxe_pkg::MODE_CUTOFF: begin
				a = (ai >= sh_thresh) ? 8'd255 : 8'd0;
				fill = (a == 8'd0);
			end
			pxe_pkg::MODE_KEY: begin
				fill = ({r, g, b} == sh_key);
				a = fill ? 8'd0 : 8'd255;
			end
			pxe_pkg::MODE_NONE: begin
				a = 8'd255;
				fill = (ai == 8'd0);
			end
			default: ;
		endcase
		if (fill) {r, g, b} = sh_fill;
		if (sh_gray) begin
			gy = (64'(pxe_pkg::GRAY_WR) * r + 64'(pxe_pkg::GRAY_WG) * g
				+ 64'(pxe_pkg::GRAY_WB) * b + 64'(pxe_pkg::GRAY_HALF)) >> 16;
			p.b0 = (gy > 255) ? 8'd255 : gy[7:0];
			p.b1 = with_a ? a : 8'd0;
			p.b2 = '0;
			p.b3 = '0;
			p.cnt = with_a ? 3'd2 : 3'd1;
		end else begin
			p.b0 = r; p.b1 = g; p.b2 = b;
			p.b3 = with_a ? a : 8'd0;
			p.cnt = with_a ? 3'd4 : 3'd3;
		end
		return p;
	endfunction

	// Send one pixel request; compute its expectation on acceptance.
	// Valid stays high after acceptance until a gap or an idle wait drops it.
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] a, input bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		blue_in <= b; green_in <= g; red_in <= r; alpha_in <= a;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_px.push_back(export_pixel(b, g, r, a));
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// Write one register; only called with the pipeline empty.
	task automatic write_reg(input pxe_pkg::reg_index_t idx, input logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pxe_pkg::REG_ALPHA_MODE: sh_mode = pxe_pkg::alpha_mode_t'(val[1:0]);
			pxe_pkg::REG_GRAY_OUT:   sh_gray = val[0];
			pxe_pkg::REG_THRESHOLD:  sh_thresh = val[7:0];
			pxe_pkg::REG_KEY_COLOR:  sh_key = val;
			pxe_pkg::REG_FILL_COLOR: sh_fill = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input pxe_pkg::alpha_mode_t m, input bit gr,
			input logic [7:0] th, input logic [23:0] key, input logic [23:0] fill);
		drain_pipe();
		write_reg(pxe_pkg::REG_ALPHA_MODE, 24'(m));
		write_reg(pxe_pkg::REG_GRAY_OUT, 24'(gr));
		write_reg(pxe_pkg::REG_THRESHOLD, 24'(th));
		write_reg(pxe_pkg::REG_KEY_COLOR, key);
		write_reg(pxe_pkg::REG_FILL_COLOR, fill);
		cfg_valid <= 1'b0;
	endtask

	// Random pixel, biased toward corner values and key hits.
	task automatic send_random(input bit gaps);
		logic [7:0] a, r, g, b;
		int sel;
		a = 8'($urandom_range(0, 255));
		sel = $urandom_range(0, 9);
		if (sel == 0) a = '0;
		else if (sel == 1) a = 8'd255;
		else if (sel == 2) a = sh_thresh;
		r = 8'($urandom_range(0, 255));
		g = 8'($urandom_range(0, 255));
		b = 8'($urandom_range(0, 255));
		// Aim for the key: straight key times alpha is a plausible premultiplied value.
		if (sel == 3 || (sel == 1 && $urandom_range(0, 1))) begin
			r = 8'((int'(sh_key[23:16]) * int'(a) + 127) / 255);
			g = 8'((int'(sh_key[15:8]) * int'(a) + 127) / 255);
			b = 8'((int'(sh_key[7:0]) * int'(a) + 127) / 255);
		end
		send_pixel(b, g, r, a, gaps);
	endtask

	task automatic test_directed();
		logic [7:0] a;
		// Opaque, zero alpha, overshoot, extremes.
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
		send_pixel(8'hff, 8'hff, 8'hff, 8'h00, 0);
		send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 0);
		send_pixel(8'h12, 8'h34, 8'h56, 8'hff, 0);
		send_pixel(8'hff, 8'h80, 8'h01, 8'h01, 0);
		send_pixel(8'hff, 8'hff, 8'h00, 8'h80, 0);
		send_pixel(8'haa, 8'h55, 8'hf0, 8'hfe, 0);
		for (int m = 0; m < 4; m++) begin
			set_all(pxe_pkg::alpha_mode_t'(m), m[0], 8'd64, 24'hff00ff, 24'h102030);
			send_pixel(8'hff, 8'h00, 8'hff, 8'hff, 0);   // key, opaque
			send_pixel(8'h40, 8'h00, 8'h40, 8'h40, 0);   // key after un-premultiply
			a = 8'd63;
			send_pixel(8'h10, 8'h20, 8'h30, a, 0);        // just under threshold
			send_pixel(8'h10, 8'h20, 8'h30, 8'd64, 0);    // at threshold
			send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
		end
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 12; ph++) begin
			set_all(pxe_pkg::alpha_mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				(ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom_range(0, 255)),
				(ph == 2) ? 24'h000000 : 24'($urandom),
				(ph == 3) ? 24'h000000 : (ph == 4) ? 24'hffffff : 24'($urandom));
			repeat (120) send_random(1);
		end
	endtask

	// Stall the sink for a long stretch so the pipeline fills and holds its input.
	task automatic test_backpressure();
		drain_pipe();
		fork
			begin
				long_hold <= 1'b1;
				repeat (60) @(posedge clk);
				long_hold <= 1'b0;
			end
		join_none
		repeat (40) send_random(0);
		// Pause until every expected pixel has come back.
		in_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (60) send_random(1);
	endtask

	task automatic test_no_gaps();
		set_all(pxe_pkg::MODE_KEY, 1'b0, 8'd128, 24'h00ff00, 24'h0000ff);
		sink_idle_ok = 1'b0;
		repeat (290) send_random(0);
	endtask

	// Sink: random idle bursts, a long hold-off on request, and the checker.
	always @(posedge clk) begin
		packed_px_t exp_px;
		if (out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected pixel %h %h %h %h cnt %0d", $time,
					byte0, byte1, byte2, byte3, byte_count);
				err_cnt++;
			end else begin
				exp_px = pending_px.pop_front();
				if (byte0 !== exp_px.b0) begin
					$display("%0t: byte0 expected %h actual %h", $time, exp_px.b0, byte0);
					err_cnt++;
				end
				if (byte1 !== exp_px.b1) begin
					$display("%0t: byte1 expected %h actual %h", $time, exp_px.b1, byte1);
					err_cnt++;
				end
				if (byte2 !== exp_px.b2) begin
					$display("%0t: byte2 expected %h actual %h", $time, exp_px.b2, byte2);
					err_cnt++;
				end
				if (byte3 !== exp_px.b3) begin
					$display("%0t: byte3 expected %h actual %h", $time, exp_px.b3, byte3);
					err_cnt++;
				end
				if (byte_count !== exp_px.cnt) begin
					$display("%0t: byte_count expected %0d actual %0d", $time,
						exp_px.cnt, byte_count);
					err_cnt++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold) begin
			out_ready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= 1'b0;
		end else if (sink_idle_ok && out_ready && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			sink_hold <= $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		sh_mode = pxe_pkg::MODE_FULL;
		sh_gray = 1'b0;
		sh_thresh = 8'd64;
		sh_key = 24'hff00ff;
		sh_fill = 24'hffffff;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_configs();
		test_backpressure();
		test_no_gaps();
		drain_pipe();
		if (err_cnt == 0)
			$display("premultiplied_pixel_export regression: pass");
		else
			$display("premultiplied_pixel_export regression: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("premultiplied_pixel_export regression: fail");
		$finish;
	end

endmodule
